[rtl/core/pdt_pkg.sv]
// Shared types and constants for the PWM duty text parser.
package pdt_pkg;

    // One input item: a character of the duty text or the end marker
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } char_item_t;

    // One result item
    typedef struct packed {
        logic        valid_res;
        logic [9:0]  duty_permille;
        logic [16:0] pulse_count;
    } res_item_t;

    // Parsed job handed from the front parser to the count unit
    typedef struct packed {
        logic       ok;
        logic [9:0] duty;
    } job_t;

    localparam logic [7:0]  CHAR_ZERO     = 8'h30;
    localparam logic [7:0]  CHAR_NINE     = 8'h39;
    localparam logic [7:0]  CHAR_DOT      = 8'h2E;
    localparam logic [9:0]  DUTY_FULL     = 10'd1000;
    localparam logic [25:0] ROUND_HALF    = 26'd500;
    localparam logic [15:0] PERIOD_RESET  = 16'hFFFF;
    localparam logic [2:0]  FRAC_KEEP     = 3'd3;
    localparam logic [2:0]  FRAC_SAT      = 3'd4;
    localparam logic [3:0]  ROUND_DIGIT   = 4'd5;

    // Division by 1000 as multiply by floor(2^36/1000), then one correction step
    localparam logic [26:0] RECIP_1000    = 27'd68719476;
    localparam int          RECIP_SHIFT   = 36;
    localparam logic [26:0] DIVISOR       = 27'd1000;

endpackage

[rtl/core/pdt_front.sv]
// Front parser: takes duty text characters and emits one job per end item.
module pdt_front
    import pdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  char_item_t char_item,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    logic       rejected_reg, rejected_next;
    logic       in_fraction_reg, in_fraction_next;
    logic       whole_value_reg, whole_value_next;
    logic [9:0] fraction_value_reg, fraction_value_next;
    logic [2:0] frac_count_reg, frac_count_next;
    logic       saw_whole_reg, saw_whole_next;
    logic       saw_frac_reg, saw_frac_next;
    logic       frac_nonzero_reg, frac_nonzero_next;
    logic       round_up_reg, round_up_next;

    logic       accept;
    logic       is_digit;
    logic [3:0] digit;
    logic [9:0] frac_scaled;
    logic [9:0] duty_frac;
    logic       ok;

    assign char_ready = !q_full;
    assign accept     = char_valid && char_ready;
    assign push       = accept && char_item.end_of_text;

    // Classify the character
    always_comb
    begin
        is_digit = char_item.char_code inside {[CHAR_ZERO:CHAR_NINE]};
        digit    = is_digit ? 4'(char_item.char_code - CHAR_ZERO) : 4'd0;
    end

    // Scale the kept fraction digits to thousandths and round
    always_comb
    begin
        case (frac_count_reg)
            3'd0:    frac_scaled = 10'd0;
            3'd1:    frac_scaled = 10'(fraction_value_reg * 10'd100);
            3'd2:    frac_scaled = 10'(fraction_value_reg * 10'd10);
            default: frac_scaled = fraction_value_reg;
        endcase
        duty_frac = frac_scaled;
        if (round_up_reg && (duty_frac < DUTY_FULL))
        begin
            duty_frac = duty_frac + 10'd1;
        end
        if (duty_frac > DUTY_FULL)
        begin
            duty_frac = DUTY_FULL;
        end
        ok = !rejected_reg && (saw_whole_reg || saw_frac_reg)
             && !(whole_value_reg && frac_nonzero_reg);
        push_job.ok   = ok;
        push_job.duty = !ok ? 10'd0 : (whole_value_reg ? DUTY_FULL : duty_frac);
    end

    // Advance the parse state
    always_comb
    begin
        rejected_next       = rejected_reg;
        in_fraction_next    = in_fraction_reg;
        whole_value_next    = whole_value_reg;
        fraction_value_next = fraction_value_reg;
        frac_count_next     = frac_count_reg;
        saw_whole_next      = saw_whole_reg;
        saw_frac_next       = saw_frac_reg;
        frac_nonzero_next   = frac_nonzero_reg;
        round_up_next       = round_up_reg;
        if (accept)
        begin
            if (char_item.end_of_text)
            begin
                rejected_next       = 1'b0;
                in_fraction_next    = 1'b0;
                whole_value_next    = 1'b0;
                fraction_value_next = 10'd0;
                frac_count_next     = 3'd0;
                saw_whole_next      = 1'b0;
                saw_frac_next       = 1'b0;
                frac_nonzero_next   = 1'b0;
                round_up_next       = 1'b0;
            end
            else if (!rejected_reg)
            begin
                if (!in_fraction_reg)
                begin
                    if (is_digit)
                    begin
                        saw_whole_next = 1'b1;
                        if (whole_value_reg || (digit > 4'd1))
                        begin
                            rejected_next = 1'b1;
                        end
                        else
                        begin
                            whole_value_next = digit[0];
                        end
                    end
                    else if (char_item.char_code == CHAR_DOT)
                    begin
                        in_fraction_next = 1'b1;
                    end
                    else
                    begin
                        rejected_next = 1'b1;
                    end
                end
                else if (!is_digit)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    saw_frac_next = 1'b1;
                    if (digit != 4'd0)
                    begin
                        frac_nonzero_next = 1'b1;
                    end
                    if (frac_count_reg < FRAC_KEEP)
                    begin
                        fraction_value_next = 10'(fraction_value_reg * 10'd10)
                                              + {6'd0, digit};
                    end
                    else if ((frac_count_reg == FRAC_KEEP) && (digit >= ROUND_DIGIT))
                    begin
                        round_up_next = 1'b1;
                    end
                    if (frac_count_reg < FRAC_SAT)
                    begin
                        frac_count_next = frac_count_reg + 3'd1;
                    end
                end
            end
        end
    end

    // Hold the parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rejected_reg       <= 1'b0;
            in_fraction_reg    <= 1'b0;
            whole_value_reg    <= 1'b0;
            fraction_value_reg <= 10'd0;
            frac_count_reg     <= 3'd0;
            saw_whole_reg      <= 1'b0;
            saw_frac_reg       <= 1'b0;
            frac_nonzero_reg   <= 1'b0;
            round_up_reg       <= 1'b0;
        end
        else
        begin
            rejected_reg       <= rejected_next;
            in_fraction_reg    <= in_fraction_next;
            whole_value_reg    <= whole_value_next;
            fraction_value_reg <= fraction_value_next;
            frac_count_reg     <= frac_count_next;
            saw_whole_reg      <= saw_whole_next;
            saw_frac_reg       <= saw_frac_next;
            frac_nonzero_reg   <= frac_nonzero_next;
            round_up_reg       <= round_up_next;
        end
    end

endmodule

[rtl/core/pdt_queue.sv]
// Two-entry job queue between the front parser and the count unit.
module pdt_queue
    import pdt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic full,
    output logic empty
);

    job_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("job queue underflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("job queue count out of range");

endmodule

[rtl/core/pdt_back.sv]
// Count unit: turns each job into a result with the rounded compare count.
module pdt_back
    import pdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [15:0] cfg_data,
    input  logic        job_valid,
    input  job_t        job,
    output logic        pop,
    output logic        res_valid,
    input  logic        res_ready,
    output res_item_t   res_item
);

    logic [15:0] timer_period_reg;
    logic [16:0] counts;
    logic        advance;

    // Stage 1: scaled product plus half
    logic        s1_valid_reg;
    job_t        s1_job_reg;
    logic [25:0] s1_x_reg;
    logic [26:0] prod_raw;

    // Stage 2: reciprocal product estimate of the quotient
    logic        s2_valid_reg;
    job_t        s2_job_reg;
    logic [25:0] s2_x_reg;
    logic [16:0] s2_q_reg;
    logic [52:0] recip_prod;

    // Stage 3: correct, clamp and register the result
    logic        res_valid_reg;
    res_item_t   res_item_reg;
    logic [26:0] q_times;
    logic [26:0] remainder;
    logic [16:0] q_fixed;
    res_item_t   res_next;

    assign counts    = {1'b0, timer_period_reg} + 17'd1;
    assign advance   = !res_valid_reg || res_ready;
    assign pop       = advance && job_valid;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // Hold the period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_period_reg <= PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            timer_period_reg <= cfg_data;
        end
    end

    always_comb
    begin
        prod_raw   = 27'(counts * job.duty);
        recip_prod = 53'(s1_x_reg * RECIP_1000);
        q_times    = 27'(s2_q_reg * 17'd1000);
        remainder  = {1'b0, s2_x_reg} - q_times;
        q_fixed    = (remainder >= DIVISOR) ? s2_q_reg + 17'd1 : s2_q_reg;
        if (q_fixed > counts)
        begin
            q_fixed = counts;
        end
        res_next.valid_res     = s2_job_reg.ok;
        res_next.duty_permille = s2_job_reg.ok ? s2_job_reg.duty : 10'd0;
        res_next.pulse_count   = s2_job_reg.ok ? q_fixed : 17'd0;
    end

    // Advance the valid bits together when the output can move
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            res_valid_reg <= s2_valid_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_job_reg   <= job;
            s1_x_reg     <= 26'(prod_raw) + ROUND_HALF;
            s2_job_reg   <= s1_job_reg;
            s2_x_reg     <= s1_x_reg;
            s2_q_reg     <= recip_prod[RECIP_SHIFT +: 17];
            res_item_reg <= res_next;
        end
    end

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_item_reg.valid_res) |->
        (res_item_reg.duty_permille == 10'd0 && res_item_reg.pulse_count == 17'd0))
        else $error("rejected result carries nonzero fields");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_item_reg.pulse_count <= counts))
        else $error("compare count exceeds period");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !advance) |=> (s2_valid_reg && $stable(s2_q_reg)))
        else $error("pipeline stage lost while stalled");

endmodule

[rtl/core/pwm_duty_text_to_pulse.sv]
// Top level of the PWM duty text parser and compare-count generator.
//
// Usage: characters of a decimal duty such as "0.3" arrive on the char
// channel, one per item, with end_of_text low; an item with end_of_text
// high closes the text and produces exactly one result on the res channel.
// The result gives a valid flag, the duty in thousandths and the timer
// compare count ((period+1)*duty+500)/1000, all zero for rejected text.
// The cfg channel writes the timer period; write it only while idle.
//
// Throughput: one item per cycle on the char channel while the job queue is not full.
// Path: an accepted end item is written to the job queue, then passes
// the three-stage count unit (product, reciprocal multiply, correction
// step for the division by 1000) before its result is shown.
// Stall: a two-entry job queue sits between the parser and the count
// unit; when res_ready is low the count unit holds, the queue fills and
// char_ready drops only once it is full.
// Reset: parse state clears, the queue empties, the period returns to
// 65535 and no result is pending.
module pwm_duty_text_to_pulse
    import pdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  char_item_t  char_item,
    output logic        res_valid,
    input  logic        res_ready,
    output res_item_t   res_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic push;
    job_t push_job;
    logic pop;
    job_t pop_job;
    logic q_full;
    logic q_empty;

    // Period writes are always accepted
    assign cfg_ready = 1'b1;

    pdt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    pdt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    pdt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .job_valid (!q_empty),
        .job       (pop_job),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

[verif/duty_scoreboard_pkg.sv]
// Scoreboard class for the PWM duty text parser: duty and count prediction plus result checks.
package duty_scoreboard_pkg;
    import pdt_pkg::*;

    class duty_scoreboard;
        // Period register copy and running parse state of the text
        logic [15:0] period;
        bit          rejected;
        bit          in_frac;
        bit          whole_one;
        bit          saw_whole;
        bit          saw_frac;
        bit          frac_nonzero;
        bit          round_up;
        logic [9:0]  frac_val;
        logic [2:0]  frac_cnt;
        res_item_t   duty_q[$];
        int          errors;

        function new();
            period = PERIOD_RESET;
            errors = 0;
            clear_text();
        endfunction

        // Drop all parse state, ready for the next text
        function void clear_text();
            rejected     = 1'b0;
            in_frac      = 1'b0;
            whole_one    = 1'b0;
            saw_whole    = 1'b0;
            saw_frac     = 1'b0;
            frac_nonzero = 1'b0;
            round_up     = 1'b0;
            frac_val     = '0;
            frac_cnt     = '0;
        endfunction

        function void set_period(logic [15:0] p);
            period = p;
        endfunction

        function int pending();
            return duty_q.size();
        endfunction

        // Advance the parse on a character; on the end item work out the result
        function void note_char(char_item_t it);
            bit              is_digit;
            logic [3:0]      d;
            bit              ok;
            logic [10:0]     f;
            logic [2:0]      n;
            logic [9:0]      duty;
            longint unsigned counts;
            longint unsigned p64;
            res_item_t       r;

            if (!it.end_of_text)
            begin
                is_digit = (it.char_code >= CHAR_ZERO) && (it.char_code <= CHAR_NINE);
                d = is_digit ? 4'(it.char_code - CHAR_ZERO) : 4'd0;
                if (rejected)
                begin
                    // ignore everything until the end item
                end
                else if (!in_frac)
                begin
                    if (is_digit)
                    begin
                        saw_whole = 1'b1;
                        if (whole_one || (d > 4'd1))
                            rejected = 1'b1;
                        else
                            whole_one = d[0];
                    end
                    else if (it.char_code == CHAR_DOT)
                        in_frac = 1'b1;
                    else
                        rejected = 1'b1;
                end
                else if (!is_digit)
                    rejected = 1'b1;
                else
                begin
                    saw_frac = 1'b1;
                    if (d != 4'd0)
                        frac_nonzero = 1'b1;
                    if (frac_cnt < FRAC_KEEP)
                        frac_val = 10'(frac_val * 10 + d);
                    else if ((frac_cnt == FRAC_KEEP) && (d >= ROUND_DIGIT))
                        round_up = 1'b1;
                    if (frac_cnt < FRAC_SAT)
                        frac_cnt = frac_cnt + 3'd1;
                end
                return;
            end

            ok = !rejected && (saw_whole || saw_frac) && !(whole_one && frac_nonzero);
            duty = '0;
            r = '0;
            if (ok)
            begin
                if (whole_one)
                    duty = DUTY_FULL;
                else
                begin
                    // scale the kept digits up to thousandths, then round and clamp
                    f = {1'b0, frac_val};
                    for (n = frac_cnt; n < FRAC_KEEP; n++)
                        f = 11'(f * 10);
                    if (round_up && (f < 11'(DUTY_FULL)))
                        f = f + 11'd1;
                    if (f > 11'(DUTY_FULL))
                        f = 11'(DUTY_FULL);
                    duty = f[9:0];
                end
                counts = 64'(period) + 64'd1;
                p64 = (counts * 64'(duty) + 64'(ROUND_HALF)) / 64'(DUTY_FULL);
                if (p64 > counts)
                    p64 = counts;
                r.valid_res     = 1'b1;
                r.duty_permille = duty;
                r.pulse_count   = p64[16:0];
            end
            duty_q.push_back(r);
            clear_text();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // Compare one received result with the oldest expected one
        task check_result(res_item_t got);
            res_item_t want;

            if (duty_q.size() == 0)
            begin
                report($sformatf("unexpected result valid=%0d duty=%0d count=%0d",
                                 got.valid_res, got.duty_permille, got.pulse_count));
            end
            else
            begin
                want = duty_q.pop_front();
                if (got.valid_res !== want.valid_res)
                    report($sformatf("valid_res got %0d want %0d",
                                     got.valid_res, want.valid_res));
                if (got.duty_permille !== want.duty_permille)
                    report($sformatf("duty_permille got %0d want %0d",
                                     got.duty_permille, want.duty_permille));
                if (got.pulse_count !== want.pulse_count)
                    report($sformatf("pulse_count got %0d want %0d (period %0d)",
                                     got.pulse_count, want.pulse_count, period));
            end
        endtask
    endclass

endpackage

[verif/tb.sv]
// Top-level testbench for the PWM duty text parser: stimulus, handshakes and final verdict.
module tb;
    import pdt_pkg::*;
    import duty_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TEXTS_PER_PHASE = 11;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_ready;
    char_item_t  char_item = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_item_t   res_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    duty_scoreboard sb;
    int             send_idle = 30;
    int             recv_idle = 52;
    int             cycle_count = 0;
    logic [7:0]     text_q[$];
    logic [15:0]    period_tab[6];

    pwm_duty_text_to_pulse dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Take results and stall the result channel at random
    always @(posedge clk)
    begin
        if (res_valid && res_ready)
            sb.check_result(res_item);
        res_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Offer one item, with random gaps before it, and hold it until taken
    task send_char(input char_item_t it);
        while ($urandom_range(0, 99) < send_idle)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_item  <= it;
        do
            @(posedge clk);
        while (!(char_valid && char_ready));
        sb.note_char(it);
    endtask

    // Send the characters in text_q, then the end item
    task send_text();
        char_item_t it;

        foreach (text_q[i])
        begin
            it.char_code   = text_q[i];
            it.end_of_text = 1'b0;
            send_char(it);
        end
        it.char_code   = 8'($urandom_range(0, 255));
        it.end_of_text = 1'b1;
        send_char(it);
    endtask

    task send_str(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
        send_text();
    endtask

    // Drop valid and wait until every expected result is in, then let the pipe settle
    task wait_drained();
        char_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_period(input logic [15:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        sb.set_period(v);
    endtask

    // Build a random text: mostly well-formed, some broken, some noise
    task make_text();
        int  kind;
        int  nfrac;
        bit  one;
        logic [7:0] c;

        text_q.delete();
        kind = $urandom_range(0, 99);
        one  = ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(0, 2)) text_q.push_back(CHAR_ZERO);
        if ($urandom_range(0, 3) != 0)
            text_q.push_back(one ? CHAR_ZERO + 8'd1 : CHAR_ZERO);
        if ($urandom_range(0, 4) != 0)
        begin
            text_q.push_back(CHAR_DOT);
            nfrac = $urandom_range(0, 6);
            for (int i = 0; i < nfrac; i++)
            begin
                if (one && ($urandom_range(0, 3) != 0))
                    text_q.push_back(CHAR_ZERO);
                else
                    text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        if ((kind >= 60) && (kind < 85))
        begin
            // insert one extra character at a random place, usually one that breaks the text
            case ($urandom_range(0, 3))
                0: c = 8'($urandom_range(0, 255));
                1: c = CHAR_DOT;
                2: c = CHAR_ZERO + 8'($urandom_range(2, 9));
                default: c = 8'h00;
            endcase
            text_q.insert($urandom_range(0, text_q.size()), c);
        end
        else if (kind >= 85)
        begin
            text_q.delete();
            repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        sb = new();
        period_tab[0] = 16'd0;
        period_tab[1] = 16'hFFFF;
        period_tab[2] = 16'd1;
        period_tab[3] = 16'd999;
        period_tab[4] = 16'($urandom_range(2, 65533));
        period_tab[5] = 16'hFFFE;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts at the reset period
        send_str("");
        send_str(".");
        send_str("..");
        send_str("2");
        send_str("1.");
        send_str("1.5");
        send_str(".9995");
        text_q = '{8'h00};
        send_text();
        text_q = '{8'hFF};
        send_text();

        // Random texts over several periods and idle mixes
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    send_idle = 30;
                    recv_idle = 52;
                end
                1:
                begin
                    send_idle = 52;
                    recv_idle = 30;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            wait_drained();
            write_period(period_tab[ph]);
            repeat (TEXTS_PER_PHASE)
            begin
                make_text();
                send_text();
            end
        end

        wait_drained();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
